FILE: design/java_class_name_scanner_core_assert.svh
// Assertion macros for the class name scanner core.
// Used by the top level only; expects a clock named clk and reset named rst.
`ifndef JAVA_CLASS_NAME_SCANNER_CORE_ASSERT_SVH
`define JAVA_CLASS_NAME_SCANNER_CORE_ASSERT_SVH

// checked outside reset
`define JCNS_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define JCNS_CHECK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/jcns_pkg.sv
// Shared types, codes and constants for the class name scanner.
// No dependencies.
`default_nettype none

package jcns_pkg;

  localparam int QDEPTH = 4;
  localparam int QIDX_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [3:0] MODE_NORMAL     = 4'd0;
  localparam logic [3:0] MODE_SLASH      = 4'd1;
  localparam logic [3:0] MODE_LINE       = 4'd2;
  localparam logic [3:0] MODE_BLOCK      = 4'd3;
  localparam logic [3:0] MODE_BLOCK_STAR = 4'd4;
  localparam logic [3:0] MODE_STR        = 4'd5;
  localparam logic [3:0] MODE_STR_ESC    = 4'd6;
  localparam logic [3:0] MODE_CHR        = 4'd7;
  localparam logic [3:0] MODE_CHR_ESC    = 4'd8;
  localparam logic [3:0] MODE_IDENT      = 4'd9;
  localparam logic [3:0] MODE_NAME       = 4'd10;

  localparam logic [1:0] KIND_CHAR    = 2'd0;
  localparam logic [1:0] KIND_DONE    = 2'd1;
  localparam logic [1:0] KIND_INVALID = 2'd2;
  localparam logic [1:0] KIND_NONE    = 2'd3;

  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_USCORE = 8'h5f;

  localparam logic [2:0] KW_LEN = 3'd5;

  typedef struct packed {
    logic letter;
    logic digit;
    logic slash;
    logic star;
    logic dquote;
    logic squote;
    logic bslash;
    logic newline;
    logic blank;
  } byte_class_t;

  typedef struct packed {
    logic [7:0]  c;
    logic        eof;
    logic        sof;
    byte_class_t cls;
  } lex_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] ch;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [QCNT_W-1:0] front_count;
  } front_stat_t;

  typedef struct packed {
    logic [QCNT_W-1:0] res_count;
  } back_stat_t;

  // letters of the keyword "class"
  function automatic logic [7:0] kw_char(input logic [2:0] idx);
    logic [7:0] r;
    unique case (idx)
      3'd0:    r = 8'h63;
      3'd1:    r = 8'h6c;
      3'd2:    r = 8'h61;
      3'd3:    r = 8'h73;
      3'd4:    r = 8'h73;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic byte_class_t classify(input logic [7:0] c);
    byte_class_t k;
    k.letter  = (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || (c == CH_USCORE);
    k.digit   = (c >= 8'h30 && c <= 8'h39);
    k.slash   = (c == CH_SLASH);
    k.star    = (c == CH_STAR);
    k.dquote  = (c == CH_DQUOTE);
    k.squote  = (c == CH_SQUOTE);
    k.bslash  = (c == CH_BSLASH);
    k.newline = (c == CH_NL);
    k.blank   = (c <= CH_SPACE);
    return k;
  endfunction

endpackage

`default_nettype wire

FILE: design/jcns_front.sv
// Front end: accepts input items, classifies the byte, queues classified items.
// Depends on jcns_pkg.
`default_nettype none

module jcns_front import jcns_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  data_byte,
  input  wire logic        end_of_file,
  input  wire logic        start_of_file,
  output logic             item_valid,
  output lex_item_t        item,
  input  wire logic        item_take,
  output front_stat_t      stat
);

  lex_item_t         mem [QDEPTH];
  logic [QIDX_W-1:0] wr_ptr;
  logic [QIDX_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              wr_en;
  logic              rd_en;
  lex_item_t         wr_item;

  assign full       = (count == QCNT_W'(QDEPTH));
  assign item_valid = (count != '0);
  assign wr_en      = push && !full;
  assign rd_en      = item_take && item_valid;
  assign item       = mem[rd_ptr];
  assign stat.front_count = count;

  always_comb begin
    wr_item.c   = data_byte;
    wr_item.eof = end_of_file;
    wr_item.sof = start_of_file;
    wr_item.cls = classify(data_byte);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/jcns_back.sv
// Back end: lexer state machine over classified items, result queue to output.
// Depends on jcns_pkg.
`default_nettype none

module jcns_back import jcns_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  input  wire lex_item_t   item,
  output logic             item_take,
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       kind,
  output logic [7:0]       name_char,
  output logic             last,
  output back_stat_t       stat
);

  logic [3:0] lex_mode;
  logic [2:0] keyword_index;
  logic       keyword_mismatch;
  logic       class_seen;
  logic       scan_done;

  logic [3:0] lex_mode_next;
  logic [2:0] keyword_index_next;
  logic       keyword_mismatch_next;
  logic       class_seen_next;
  logic       scan_done_next;

  logic [3:0] m;
  logic [2:0] ki;
  logic       km;
  logic       cs;
  logic       sd;
  logic       do_norm;
  logic       ident_ch;
  logic       res_v;
  result_t    res;

  result_t           mem [QDEPTH];
  logic [QIDX_W-1:0] wr_ptr;
  logic [QIDX_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              wr_en;
  logic              rd_en;

  assign item_take = item_valid && (count != QCNT_W'(QDEPTH));
  assign ident_ch  = item.cls.letter || item.cls.digit;

  always_comb begin
    m  = item.sof ? MODE_NORMAL : lex_mode;
    ki = item.sof ? 3'd0 : keyword_index;
    km = item.sof ? 1'b0 : keyword_mismatch;
    cs = item.sof ? 1'b0 : class_seen;
    sd = item.sof ? 1'b0 : scan_done;

    lex_mode_next         = m;
    keyword_index_next    = ki;
    keyword_mismatch_next = km;
    class_seen_next       = cs;
    scan_done_next        = sd;
    do_norm               = 1'b0;
    res_v                 = 1'b0;
    res.kind              = KIND_CHAR;
    res.ch                = 8'h00;
    res.last              = 1'b0;

    if (!sd) begin
      if (item.eof) begin
        res_v    = 1'b1;
        res.kind = (m == MODE_NAME) ? KIND_DONE : KIND_NONE;
        res.last = 1'b1;
      end else begin
        unique case (m)
          MODE_SLASH: begin
            if (item.cls.slash) begin
              lex_mode_next = MODE_LINE;
            end else if (item.cls.star) begin
              lex_mode_next = MODE_BLOCK;
            end else begin
              do_norm = 1'b1;
            end
          end
          MODE_LINE: begin
            if (item.cls.newline) lex_mode_next = MODE_NORMAL;
          end
          MODE_BLOCK: begin
            if (item.cls.star) lex_mode_next = MODE_BLOCK_STAR;
          end
          MODE_BLOCK_STAR: begin
            if (item.cls.slash) begin
              lex_mode_next = MODE_NORMAL;
            end else if (!item.cls.star) begin
              lex_mode_next = MODE_BLOCK;
            end
          end
          MODE_STR: begin
            if (item.cls.dquote) begin
              lex_mode_next = MODE_NORMAL;
            end else if (item.cls.bslash) begin
              lex_mode_next = MODE_STR_ESC;
            end
          end
          MODE_STR_ESC: lex_mode_next = MODE_STR;
          MODE_CHR: begin
            if (item.cls.squote) begin
              lex_mode_next = MODE_NORMAL;
            end else if (item.cls.bslash) begin
              lex_mode_next = MODE_CHR_ESC;
            end
          end
          MODE_CHR_ESC: lex_mode_next = MODE_CHR;
          MODE_IDENT: begin
            if (ident_ch) begin
              if (!km && ki < KW_LEN && item.c == kw_char(ki)) begin
                keyword_index_next = ki + 3'd1;
              end else begin
                keyword_mismatch_next = 1'b1;
              end
            end else begin
              if (!km && ki == KW_LEN) class_seen_next = 1'b1;
              lex_mode_next = MODE_NORMAL;
              do_norm       = 1'b1;
            end
          end
          MODE_NAME: begin
            res_v = 1'b1;
            if (ident_ch) begin
              res.kind = KIND_CHAR;
              res.ch   = item.c;
            end else begin
              res.kind = KIND_DONE;
              res.last = 1'b1;
            end
          end
          default: do_norm = 1'b1;
        endcase

        if (do_norm) begin
          if (item.cls.slash) begin
            lex_mode_next = MODE_SLASH;
          end else if (item.cls.dquote || item.cls.squote) begin
            if (class_seen_next) begin
              res_v    = 1'b1;
              res.kind = KIND_INVALID;
              res.last = 1'b1;
            end else begin
              lex_mode_next = item.cls.dquote ? MODE_STR : MODE_CHR;
            end
          end else if (item.cls.letter) begin
            if (class_seen_next) begin
              lex_mode_next = MODE_NAME;
              res_v         = 1'b1;
              res.kind      = KIND_CHAR;
              res.ch        = item.c;
            end else begin
              lex_mode_next         = MODE_IDENT;
              keyword_index_next    = (item.c == kw_char(3'd0)) ? 3'd1 : 3'd0;
              keyword_mismatch_next = (item.c != kw_char(3'd0));
            end
          end else if (item.cls.blank) begin
            lex_mode_next = MODE_NORMAL;
          end else begin
            if (class_seen_next) begin
              res_v    = 1'b1;
              res.kind = KIND_INVALID;
              res.last = 1'b1;
            end else begin
              lex_mode_next = MODE_NORMAL;
            end
          end
        end
      end
    end

    if (res_v && res.last) begin
      scan_done_next = 1'b1;
      lex_mode_next  = MODE_NORMAL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lex_mode         <= MODE_NORMAL;
      keyword_index    <= 3'd0;
      keyword_mismatch <= 1'b0;
      class_seen       <= 1'b0;
      scan_done        <= 1'b0;
    end else if (item_take) begin
      lex_mode         <= lex_mode_next;
      keyword_index    <= keyword_index_next;
      keyword_mismatch <= keyword_mismatch_next;
      class_seen       <= class_seen_next;
      scan_done        <= scan_done_next;
    end
  end

  // result queue
  assign wr_en     = item_take && res_v;
  assign empty     = (count == '0);
  assign rd_en     = pop && !empty;
  assign kind      = mem[rd_ptr].kind;
  assign name_char = mem[rd_ptr].ch;
  assign last      = mem[rd_ptr].last;
  assign stat.res_count = count;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/java_class_name_scanner_core.sv
// Class name scanner core: lexes Java source bytes and streams out the class name.
// An item is taken every cycle while full is low; it lands in a 4-deep input queue, the
// lexer takes one queued item per cycle while its 4-deep result queue has room, and a
// result is registered into the result queue before it can be popped. Sustained rate is
// one item per cycle while the result queue has room; results are popped one per cycle.
// Depends on jcns_pkg, jcns_front, jcns_back and java_class_name_scanner_core_assert.svh.
`default_nettype none

`include "java_class_name_scanner_core_assert.svh"

module java_class_name_scanner_core import jcns_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  data_byte,
  input  wire logic        end_of_file,
  input  wire logic        start_of_file,
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       kind,
  output logic [7:0]       name_char,
  output logic             last
);

  logic        item_valid;
  lex_item_t   item;
  logic        item_take;
  front_stat_t front_stat;
  back_stat_t  back_stat;

  jcns_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .data_byte     (data_byte),
    .end_of_file   (end_of_file),
    .start_of_file (start_of_file),
    .item_valid    (item_valid),
    .item          (item),
    .item_take     (item_take),
    .stat          (front_stat)
  );

  jcns_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .empty      (empty),
    .pop        (pop),
    .kind       (kind),
    .name_char  (name_char),
    .last       (last),
    .stat       (back_stat)
  );

  `JCNS_CHECK(a_front_bound, front_stat.front_count <= QCNT_W'(QDEPTH), "input queue overrun")
  `JCNS_CHECK(a_back_bound, back_stat.res_count <= QCNT_W'(QDEPTH), "result queue overrun")
  `JCNS_CHECK(a_last_kind, !empty |-> (last == (kind != KIND_CHAR)), "final flag does not match kind")
  `JCNS_CHECK_ALWAYS(a_reset_empty, rst |=> (empty && !full), "queues not empty after reset")

endmodule

`default_nettype wire
